[src/flc_pkg.sv]
// Shared constants and types of the FIR linear convolution block.
// Used by every module under src; depends on nothing else.
package flc_pkg;

  localparam int MAX_TAPS     = 32;
  localparam int SAMPLE_WIDTH = 16;
  localparam int COEF_WIDTH   = 16;

  // Field widths of the ports.
  localparam int VALUE_W = 16;
  localparam int IDX_W   = 5;
  localparam int CFG_W   = 6;
  localparam int FILT_W  = 37;

  localparam int TAP_IDX_W = $clog2(MAX_TAPS);
  localparam int TAP_CNT_W = $clog2(MAX_TAPS + 1);
  localparam int CMP_W     = (CFG_W > TAP_CNT_W) ? CFG_W : TAP_CNT_W;
  localparam int PROD_W    = SAMPLE_WIDTH + COEF_WIDTH;

  // Adder tree over the taps, padded to a power of two.
  localparam int TREE_LVLS = TAP_IDX_W;
  localparam int TREE_N    = 1 << TREE_LVLS;
  localparam int MAC_LAT   = TREE_LVLS + 1;

  // Result queue is deep enough to cover the whole issue-to-push loop.
  localparam int OQ_DEPTH  = 1 << $clog2(MAC_LAT + 3);
  localparam int OQ_PTR_W  = $clog2(OQ_DEPTH);
  localparam int OQ_CNT_W  = $clog2(OQ_DEPTH + 1);

  localparam int FQ_DEPTH  = 4;
  localparam int FQ_PTR_W  = $clog2(FQ_DEPTH);
  localparam int FQ_CNT_W  = $clog2(FQ_DEPTH + 1);

  // Operation codes passed from the front to the back.
  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_SAMPLE = 2'd1;
  localparam logic [1:0] OP_LAST   = 2'd2;

  typedef struct packed {
    logic [1:0]           kind;
    logic [TAP_IDX_W-1:0] idx;
    logic [VALUE_W-1:0]   value;
  } op_t;

  // One step issued to the multiply-accumulate pipeline.
  typedef struct packed {
    logic valid;
    logic last;
  } issue_t;

  typedef struct packed {
    logic [FILT_W-1:0] filtered;
    logic              last;
  } res_t;

  typedef logic [MAX_TAPS-1:0][SAMPLE_WIDTH-1:0] delay_arr_t;
  typedef logic [MAX_TAPS-1:0][COEF_WIDTH-1:0]   coef_arr_t;

endpackage

[src/flc_front.sv]
// Front end: accepts input beats, sorts them into load, sample and
// end-of-signal operations and holds them in a short queue. Uses flc_pkg.
module flc_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        func,
  input  logic [flc_pkg::IDX_W-1:0]   coef_index,
  input  logic signed [flc_pkg::VALUE_W-1:0] value,
  input  logic                        end_of_signal,
  output logic                        q_valid,
  output flc_pkg::op_t                q_op,
  input  logic                        q_pop
);
  import flc_pkg::*;

  op_t                 mem [FQ_DEPTH];
  logic [FQ_PTR_W-1:0] wr_ptr;
  logic [FQ_PTR_W-1:0] rd_ptr;
  logic [FQ_CNT_W-1:0] count;
  op_t                 op_in;
  logic                accept;
  logic                push;

  assign in_stall = (count == FQ_CNT_W'(FQ_DEPTH));
  assign accept   = in_valid && !in_stall;

  always_comb begin
    op_in.idx   = TAP_IDX_W'(coef_index);
    op_in.value = value;
    if (!func) begin
      op_in.kind = OP_LOAD;
    end else if (end_of_signal) begin
      op_in.kind = OP_LAST;
    end else begin
      op_in.kind = OP_SAMPLE;
    end
  end

  // A load beyond the coefficient store is taken and dropped here.
  assign push = accept && (func || (int'(coef_index) < MAX_TAPS));

  assign q_valid = (count != '0);
  assign q_op    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= op_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (q_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + FQ_CNT_W'(push) - FQ_CNT_W'(q_pop);
    end
  end

endmodule

[src/flc_back.sv]
// Back end: executes queued operations, keeps the delay line and the
// coefficients, sequences the zero-fed tail and reserves result slots.
// Uses flc_pkg.
module flc_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [flc_pkg::CFG_W-1:0]   tap_count,
  input  logic                        q_valid,
  input  flc_pkg::op_t                q_op,
  output logic                        q_pop,
  input  logic                        out_pop,
  output flc_pkg::issue_t             go,
  output flc_pkg::delay_arr_t         delay,
  output flc_pkg::coef_arr_t          coef,
  output logic [flc_pkg::MAX_TAPS-1:0] tap_en
);
  import flc_pkg::*;

  logic                 flushing;
  logic [TAP_CNT_W-1:0] flush_left;
  logic                 clear_pend;
  logic [OQ_CNT_W-1:0]  reserved;

  logic [CMP_W-1:0]     tc_wide;
  logic [TAP_CNT_W-1:0] eff_taps;
  logic                 credit;
  logic                 issue;
  logic                 issue_last;
  logic                 start_flush;
  logic                 load_en;
  logic [SAMPLE_WIDTH-1:0] shift_val;
  delay_arr_t           base;

  always_comb begin
    tc_wide = CMP_W'(tap_count);
    if (tc_wide == '0) begin
      eff_taps = TAP_CNT_W'(1);
    end else if (tc_wide > CMP_W'(MAX_TAPS)) begin
      eff_taps = TAP_CNT_W'(MAX_TAPS);
    end else begin
      eff_taps = TAP_CNT_W'(tc_wide);
    end
    for (int j = 0; j < MAX_TAPS; j++) begin
      tap_en[j] = (TAP_CNT_W'(j) < eff_taps);
    end
  end

  // A slot is free if the queue plus everything in flight stays in bounds.
  assign credit = (reserved != OQ_CNT_W'(OQ_DEPTH)) || out_pop;

  always_comb begin
    issue       = 1'b0;
    issue_last  = 1'b0;
    start_flush = 1'b0;
    load_en     = 1'b0;
    q_pop       = 1'b0;
    shift_val   = '0;
    if (flushing) begin
      issue      = credit;
      issue_last = (flush_left == TAP_CNT_W'(1));
    end else if (q_valid) begin
      if (q_op.kind == OP_LOAD) begin
        load_en = 1'b1;
        q_pop   = 1'b1;
      end else if (credit) begin
        issue     = 1'b1;
        q_pop     = 1'b1;
        shift_val = SAMPLE_WIDTH'($signed(q_op.value));
        if (q_op.kind == OP_LAST) begin
          if (eff_taps == TAP_CNT_W'(1)) begin
            issue_last = 1'b1;
          end else begin
            start_flush = 1'b1;
          end
        end
      end
    end
  end

  // The line is cleared in the cycle after the last beat of a run, once the
  // multipliers have sampled it.
  assign base = clear_pend ? '0 : delay;

  always_ff @(posedge clk) begin
    if (issue) begin
      delay <= {base[MAX_TAPS-2:0], shift_val};
    end else if (clear_pend) begin
      delay <= '0;
    end
    if (load_en) begin
      coef[q_op.idx] <= COEF_WIDTH'($signed(q_op.value));
    end
    if (rst) begin
      delay <= '0;
      coef  <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flushing   <= 1'b0;
      flush_left <= '0;
      clear_pend <= 1'b0;
      reserved   <= '0;
      go         <= '0;
    end else begin
      clear_pend <= issue && issue_last;
      go.valid   <= issue;
      go.last    <= issue_last;
      reserved   <= reserved + OQ_CNT_W'(issue) - OQ_CNT_W'(out_pop);
      if (start_flush) begin
        flushing   <= 1'b1;
        flush_left <= eff_taps - 1'b1;
      end else if (flushing && issue) begin
        flush_left <= flush_left - 1'b1;
        if (issue_last) begin
          flushing <= 1'b0;
        end
      end
    end
  end

endmodule

[src/flc_mac.sv]
// Multiply-accumulate pipeline: one product per tap, then a registered
// binary adder tree down to one exact sum. Uses flc_pkg.
module flc_mac (
  input  logic                         clk,
  input  logic                         rst,
  input  flc_pkg::issue_t              go,
  input  flc_pkg::delay_arr_t          delay,
  input  flc_pkg::coef_arr_t           coef,
  input  logic [flc_pkg::MAX_TAPS-1:0] tap_en,
  output logic                         res_valid,
  output flc_pkg::res_t                res
);
  import flc_pkg::*;

  // Heap-ordered tree: leaves at TREE_N and up, the root at index one.
  logic signed [FILT_W-1:0] node [1:2*TREE_N-1];
  logic [MAC_LAT-1:0]       vld;
  logic [MAC_LAT-1:0]       lst;

  always_ff @(posedge clk) begin
    for (int j = 0; j < TREE_N; j++) begin
      if (j < MAX_TAPS && tap_en[j]) begin
        node[TREE_N + j] <= FILT_W'($signed(PROD_W'($signed(delay[j]) * $signed(coef[j]))));
      end else begin
        node[TREE_N + j] <= '0;
      end
    end
    for (int n = 1; n < TREE_N; n++) begin
      node[n] <= node[2*n] + node[2*n+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      lst <= '0;
    end else begin
      vld <= {vld[MAC_LAT-2:0], go.valid};
      lst <= {lst[MAC_LAT-2:0], go.last};
    end
  end

  assign res_valid    = vld[MAC_LAT-1];
  assign res.filtered = node[1];
  assign res.last     = lst[MAC_LAT-1];

endmodule

[src/flc_oq.sv]
// Result queue between the adder tree and the output channel. Space is
// reserved upstream, so a push never finds it full. Uses flc_pkg.
module flc_oq (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  flc_pkg::res_t din,
  output logic          out_valid,
  input  logic          out_stall,
  output flc_pkg::res_t dout,
  output logic          pop
);
  import flc_pkg::*;

  res_t                mem [OQ_DEPTH];
  logic [OQ_PTR_W-1:0] wr_ptr;
  logic [OQ_PTR_W-1:0] rd_ptr;
  logic [OQ_CNT_W-1:0] count;

  assign out_valid = (count != '0);
  assign dout      = mem[rd_ptr];
  assign pop       = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + OQ_CNT_W'(push) - OQ_CNT_W'(pop);
    end
  end

endmodule

[src/fir_linear_convolution_top.sv]
// Top level of the FIR linear convolution block: tap count register and
// the front, back, multiply-accumulate and result queue. Uses flc_pkg.
//
// Input beats (in_valid/in_stall) are either coefficient loads (func 0)
// or samples (func 1). Each sample produces one exact Q7.30 sum over the
// taps in use; a sample with end_of_signal set is followed by as many
// further sums with zeros fed in as the taps in use less one, the last
// of the run flagged by last_of_run, after which the delay line is cleared.
// Results leave on out_valid/out_stall and hold still while stalled.
// The tap count is written through cfg_valid/cfg_ready/cfg_data, always
// ready, and should change only while the block is idle.
// Throughput is one beat per cycle on both sides while no stall is raised;
// during a tail the issue queue is not drained while the zero-fed sums go
// out, so the input is held off once that queue is full. From an accepted
// sample to its result, the path runs through the issue queue, the delay
// line update, the product register and one register per level of the
// adder tree, then the result queue. Slots are reserved at issue, so an
// output stall backs up into the issue queue, then in_stall, losing nothing.
// Reset (rst, synchronous) clears the delay line, the coefficients, the
// queues, and sets the tap count to 29.
module fir_linear_convolution_top (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               func,
  input  logic [flc_pkg::IDX_W-1:0]          coef_index,
  input  logic signed [flc_pkg::VALUE_W-1:0] value,
  input  logic                               end_of_signal,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [flc_pkg::FILT_W-1:0]  filtered,
  output logic                               last_of_run,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [flc_pkg::CFG_W-1:0]          cfg_data
);
  import flc_pkg::*;

  localparam logic [CFG_W-1:0] TAP_COUNT_RST = CFG_W'(29);

  logic [CFG_W-1:0]    tap_count;
  logic                q_valid;
  op_t                 q_op;
  logic                q_pop;
  logic                out_pop;
  issue_t              go;
  delay_arr_t          delay;
  coef_arr_t           coef;
  logic [MAX_TAPS-1:0] tap_en;
  logic                res_valid;
  res_t                res;
  res_t                head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tap_count <= TAP_COUNT_RST;
    end else if (cfg_valid && cfg_ready) begin
      tap_count <= cfg_data;
    end
  end

  flc_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .func          (func),
    .coef_index    (coef_index),
    .value         (value),
    .end_of_signal (end_of_signal),
    .q_valid       (q_valid),
    .q_op          (q_op),
    .q_pop         (q_pop)
  );

  flc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .tap_count (tap_count),
    .q_valid   (q_valid),
    .q_op      (q_op),
    .q_pop     (q_pop),
    .out_pop   (out_pop),
    .go        (go),
    .delay     (delay),
    .coef      (coef),
    .tap_en    (tap_en)
  );

  flc_mac u_mac (
    .clk       (clk),
    .rst       (rst),
    .go        (go),
    .delay     (delay),
    .coef      (coef),
    .tap_en    (tap_en),
    .res_valid (res_valid),
    .res       (res)
  );

  flc_oq u_oq (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .din       (res),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .dout      (head),
    .pop       (out_pop)
  );

  assign filtered    = $signed(head.filtered);
  assign last_of_run = head.last;

endmodule
